@@ sv/psc_pkg.sv @@
// Shared types, constants and helper functions of the phase shift classifier.
`default_nettype none

package psc_pkg;

   localparam int PORT_COUNT = 3;
   localparam int PORT_W     = 2;
   localparam int ANGLE_W    = 9;
   localparam int SHIFT_W    = 3;
   localparam int CUR_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;

   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic [SHIFT_W-1:0]        shift_type;
   typedef logic signed [CUR_W-1:0]   cur_type;
   typedef logic [PORT_W-1:0]         port_type;

   // Request codes
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_CALC = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_ENABLE = 2'd1;

   // Installation types
   localparam logic PHASE_SINGLE = 1'b0;
   localparam logic PHASE_THREE  = 1'b1;

   // Angle handling
   localparam int FRAC_BITS = 11;
   localparam logic [32:0] ROUND_HALF = 33'd1024;
   localparam logic [21:0] POS_LIMIT  = 22'd179;
   localparam logic [21:0] NEG_LIMIT  = 22'd180;

   // Result of the shared compare unit
   typedef struct packed {
      logic signed [CUR_W:0] diff;
      logic                  lt;
   } cmp_res_type;

   // Bin an angle into its 60-degree sextant, centered on multiples of 60
   function automatic shift_type sextant(angle_type a);
      logic signed [9:0] t;
      logic [8:0]        u;
      shift_type         s;
      t = {a[ANGLE_W-1], a} + 10'sd30;
      if (t < 10'sd0) begin
         t = t + 10'sd360;
      end
      u = t[8:0];
      if (u < 9'd60) begin
         s = 3'd0;
      end else if (u < 9'd120) begin
         s = 3'd1;
      end else if (u < 9'd180) begin
         s = 3'd2;
      end else if (u < 9'd240) begin
         s = 3'd3;
      end else if (u < 9'd300) begin
         s = 3'd4;
      end else begin
         s = 3'd5;
      end
      return s;
   endfunction

   // Single-phase sextant to shift map
   function automatic shift_type one_phase_map(shift_type s);
      shift_type r;
      case (s)
         3'd2, 3'd3, 3'd4: begin
            r = 3'd3;
         end
         default: begin
            r = 3'd0;
         end
      endcase
      return r;
   endfunction

   // Add an offset to a shift, wrapping at six
   function automatic shift_type add_mod6(shift_type b, shift_type k);
      logic [SHIFT_W:0] s;
      s = {1'b0, b} + {1'b0, k};
      if (s >= 4'd6) begin
         s = s - 4'd6;
      end
      return s[SHIFT_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ sv/psc_conv.sv @@
// Q20.11 angle to whole degrees, rounded half away from zero and saturated.
`default_nettype none

module psc_conv
   import psc_pkg::*;
(
   input  wire logic signed [31:0] angle_q,
   output angle_type               angle_deg
);

   logic [32:0] mag;
   logic [32:0] rnd;
   logic [21:0] whole;

   // Round the magnitude, then restore the sign and clamp
   always_comb begin
      if (angle_q[31]) begin
         mag = 33'd0 - {angle_q[31], angle_q};
      end else begin
         mag = {1'b0, angle_q};
      end
      rnd   = mag + ROUND_HALF;
      whole = rnd[32:FRAC_BITS];
      if (angle_q[31]) begin
         if (whole > NEG_LIMIT) begin
            angle_deg = -9'sd180;
         end else begin
            angle_deg = 9'sd0 - angle_type'(whole[ANGLE_W-1:0]);
         end
      end else begin
         if (whole > POS_LIMIT) begin
            angle_deg = 9'sd179;
         end else begin
            angle_deg = angle_type'(whole[ANGLE_W-1:0]);
         end
      end
   end

endmodule

`default_nettype wire

@@ sv/psc_cmp.sv @@
// Shared signed subtract and compare unit used by the sequencer.
`default_nettype none

module psc_cmp
   import psc_pkg::*;
(
   input  wire cur_type  op_a,
   input  wire cur_type  op_b,
   output cmp_res_type   res
);

   // Widen by one bit so the difference never overflows
   always_comb begin
      res.diff = {op_a[CUR_W-1], op_a} - {op_b[CUR_W-1], op_b};
      res.lt   = res.diff[CUR_W];
   end

endmodule

`default_nettype wire

@@ sv/phase_shift_classifier.sv @@
// Top level of the phase shift classifier: port storage and the calculate sequencer.
`default_nettype none

// A push (req_mode 0) is stored when it is accepted and busy stays low. A
// calculate (req_mode 1) holds busy high while the sequencer runs: one port a
// cycle through the sextant unit in single-phase mode, or three compare-exchange
// steps through the shared comparator and then the leading test in three-phase
// mode. rsp_valid pulses in the cycle in which busy drops, so a new request may
// start in the rsp_valid cycle. The pulse is shown for that one cycle only and
// cannot be held off, while the shift outputs hold their value. csr_ready is
// always high; write registers only while the block is idle.
module phase_shift_classifier
   import psc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_mode,
   input  wire logic [1:0]            req_port_index,
   input  wire logic signed [31:0]    req_angle_q,
   input  wire logic signed [31:0]    req_current_rms,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_shift_port0,
   output logic [2:0]                 rsp_shift_port1,
   output logic [2:0]                 rsp_shift_port2,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ONE,
      ST_SORT,
      ST_LEAD
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic phase_mode_ff, phase_mode_in;
   logic [PORT_COUNT-1:0] port_enable_ff, port_enable_in;

   angle_type port_angle_ff   [PORT_COUNT];
   angle_type port_angle_in   [PORT_COUNT];
   cur_type   port_current_ff [PORT_COUNT];
   cur_type   port_current_in [PORT_COUNT];
   shift_type port_shift_ff   [PORT_COUNT];
   shift_type port_shift_in   [PORT_COUNT];

   // Working copies, ranked by current during the sort
   angle_type work_ang_ff [PORT_COUNT];
   angle_type work_ang_in [PORT_COUNT];
   cur_type   work_cur_ff [PORT_COUNT];
   cur_type   work_cur_in [PORT_COUNT];
   port_type  work_idx_ff [PORT_COUNT];
   port_type  work_idx_in [PORT_COUNT];

   logic        accept;
   angle_type   push_deg;
   cur_type     op_a;
   cur_type     op_b;
   cmp_res_type cmp_res;
   angle_type   one_ang;
   shift_type   base;
   shift_type   second_shift;
   shift_type   third_shift;
   logic        lead;

   psc_conv u_conv (
      .angle_q   (req_angle_q),
      .angle_deg (push_deg)
   );

   psc_cmp u_cmp (
      .op_a (op_a),
      .op_b (op_b),
      .res  (cmp_res)
   );

   assign busy            = (state_ff != ST_IDLE);
   assign accept          = start && !busy;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_shift_port0 = port_shift_ff[0];
   assign rsp_shift_port1 = port_shift_ff[1];
   assign rsp_shift_port2 = port_shift_ff[2];

   // Steer operands into the shared comparator
   always_comb begin
      case (state_ff)
         ST_SORT: begin
            if (step_ff == 2'd1) begin
               op_a = work_cur_ff[1];
               op_b = work_cur_ff[2];
            end else begin
               op_a = work_cur_ff[0];
               op_b = work_cur_ff[1];
            end
         end
         default: begin
            op_a = cur_type'({{(CUR_W-ANGLE_W){work_ang_ff[0][ANGLE_W-1]}}, work_ang_ff[0]});
            op_b = cur_type'({{(CUR_W-ANGLE_W){work_ang_ff[1][ANGLE_W-1]}}, work_ang_ff[1]});
         end
      endcase
   end

   // Select the port angle for the single-phase step
   always_comb begin
      case (step_ff)
         2'd1: begin
            one_ang = work_ang_ff[1];
         end
         2'd2: begin
            one_ang = work_ang_ff[2];
         end
         default: begin
            one_ang = work_ang_ff[0];
         end
      endcase
   end

   // Leader's sextant and the offsets for the other two ports
   always_comb begin
      base = sextant(work_ang_ff[0]);
      if (cmp_res.diff[CUR_W]) begin
         lead = (cmp_res.diff < -33'sd180);
      end else begin
         lead = (cmp_res.diff < 33'sd180);
      end
      if (lead) begin
         second_shift = add_mod6(base, 3'd4);
         third_shift  = add_mod6(base, 3'd2);
      end else begin
         second_shift = add_mod6(base, 3'd2);
         third_shift  = add_mod6(base, 3'd4);
      end
   end

   // Next state of the sequencer and all storage
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      rsp_valid_in   = 1'b0;
      phase_mode_in  = phase_mode_ff;
      port_enable_in = port_enable_ff;
      port_angle_in   = port_angle_ff;
      port_current_in = port_current_ff;
      port_shift_in   = port_shift_ff;
      work_ang_in     = work_ang_ff;
      work_cur_in     = work_cur_ff;
      work_idx_in     = work_idx_ff;

      // Register writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PHASE_MODE: begin
               phase_mode_in = csr_wdata[0];
            end
            CSR_PORT_ENABLE: begin
               port_enable_in = csr_wdata[PORT_COUNT-1:0];
            end
            default: begin
               phase_mode_in = phase_mode_ff;
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_PUSH) begin
                  // Store the port; index three drops the transfer
                  for (int p = 0; p < PORT_COUNT; p++) begin
                     if (req_port_index == port_type'(p)) begin
                        port_angle_in[p]   = push_deg;
                        port_current_in[p] = req_current_rms;
                     end
                  end
               end else begin
                  // Load the working copies and start the sequence
                  for (int p = 0; p < PORT_COUNT; p++) begin
                     work_ang_in[p] = port_angle_ff[p];
                     work_cur_in[p] = port_current_ff[p];
                     work_idx_in[p] = port_type'(p);
                  end
                  step_in = 2'd0;
                  if (phase_mode_ff == PHASE_THREE) begin
                     state_in = ST_SORT;
                  end else begin
                     state_in = ST_ONE;
                  end
               end
            end
         end
         ST_ONE: begin
            // One port a cycle; disabled ports hold their shift
            for (int p = 0; p < PORT_COUNT; p++) begin
               if (step_ff == 2'(p) && port_enable_ff[p]) begin
                  port_shift_in[p] = one_phase_map(sextant(one_ang));
               end
            end
            if (step_ff == 2'(PORT_COUNT - 1)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         ST_SORT: begin
            // Compare-exchange: swap on a strictly smaller first current
            if (cmp_res.lt) begin
               if (step_ff == 2'd1) begin
                  work_ang_in[1] = work_ang_ff[2];
                  work_ang_in[2] = work_ang_ff[1];
                  work_cur_in[1] = work_cur_ff[2];
                  work_cur_in[2] = work_cur_ff[1];
                  work_idx_in[1] = work_idx_ff[2];
                  work_idx_in[2] = work_idx_ff[1];
               end else begin
                  work_ang_in[0] = work_ang_ff[1];
                  work_ang_in[1] = work_ang_ff[0];
                  work_cur_in[0] = work_cur_ff[1];
                  work_cur_in[1] = work_cur_ff[0];
                  work_idx_in[0] = work_idx_ff[1];
                  work_idx_in[1] = work_idx_ff[0];
               end
            end
            if (step_ff == 2'd2) begin
               state_in = ST_LEAD;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         ST_LEAD: begin
            // Assign the leader's sextant and the offset sextants
            for (int p = 0; p < PORT_COUNT; p++) begin
               if (work_idx_ff[0] == port_type'(p)) begin
                  port_shift_in[p] = base;
               end else if (work_idx_ff[1] == port_type'(p)) begin
                  port_shift_in[p] = second_shift;
               end else begin
                  port_shift_in[p] = third_shift;
               end
            end
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration and port state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_mode_ff  <= PHASE_SINGLE;
         port_enable_ff <= '1;
         for (int p = 0; p < PORT_COUNT; p++) begin
            port_angle_ff[p]   <= '0;
            port_current_ff[p] <= '0;
            port_shift_ff[p]   <= '0;
         end
      end else begin
         phase_mode_ff   <= phase_mode_in;
         port_enable_ff  <= port_enable_in;
         port_angle_ff   <= port_angle_in;
         port_current_ff <= port_current_in;
         port_shift_ff   <= port_shift_in;
      end
   end

   // Working copies
   always_ff @(posedge clock) begin
      work_ang_ff <= work_ang_in;
      work_cur_ff <= work_cur_in;
      work_idx_ff <= work_idx_in;
   end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the phase shift classifier: scoreboard class and stimulus drivers.
module tb;
   import psc_pkg::*;

   // Shifts of all three ports as one value, port 0 in the low bits
   typedef shift_type [PORT_COUNT-1:0] shift_set_type;

   // Keeps a copy of the port state and predicts the shifts of each calculate
   class shift_tracker;
      localparam int HALF_DEG     = 1 << (FRAC_BITS - 1);
      localparam int MIN_DEG      = -180;
      localparam int MAX_DEG      = 179;
      localparam int SEXTANT_DEG  = 60;
      localparam int HALF_SEXTANT = 30;
      localparam int TURN_DEG     = 360;
      localparam int HALF_TURN    = 180;
      localparam int SHIFT_COUNT  = 6;

      angle_type     port_deg [PORT_COUNT];
      cur_type       port_cur [PORT_COUNT];
      shift_type     port_shift [PORT_COUNT];
      logic          phase_mode;
      logic [2:0]    port_enable;
      shift_set_type expected_shifts [$];
      int            fail_count;

      function new();
         int p;
         for (p = 0; p < PORT_COUNT; p++) begin
            port_deg[p]   = '0;
            port_cur[p]   = '0;
            port_shift[p] = '0;
         end
         phase_mode  = PHASE_SINGLE;
         port_enable = 3'b111;
         fail_count  = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_PHASE_MODE: begin
               phase_mode = data[0];
            end
            CSR_PORT_ENABLE: begin
               port_enable = data;
            end
            default: begin
            end
         endcase
      endfunction

      // Round half away from zero to whole degrees, then clamp
      function angle_type round_degrees(logic signed [31:0] q);
         longint v;
         longint r;
         v = longint'(q);
         if (v >= 0) begin
            r = (v + HALF_DEG) >>> FRAC_BITS;
         end else begin
            r = -((-v + HALF_DEG) >>> FRAC_BITS);
         end
         if (r < MIN_DEG) begin
            r = MIN_DEG;
         end
         if (r > MAX_DEG) begin
            r = MAX_DEG;
         end
         return angle_type'(r);
      endfunction

      // Sextants are centered on multiples of 60 degrees
      function shift_type bin_sextant(angle_type a);
         int t;
         t = int'(a) + HALF_SEXTANT;
         if (t < 0) begin
            t += TURN_DEG;
         end
         return shift_type'((t / SEXTANT_DEG) % SHIFT_COUNT);
      endfunction

      // Sextants 2..4 map to shift 3 (half a turn away), the rest to zero
      function shift_type one_phase_shift(shift_type s);
         return (s >= 3'd2 && s <= 3'd4) ? 3'd3 : 3'd0;
      endfunction

      function bit leads(angle_type a, angle_type b);
         int d;
         d = int'(a) - int'(b);
         if (d < 0) begin
            d += TURN_DEG;
         end
         return d < HALF_TURN;
      endfunction

      function shift_type rotate(shift_type b, int k);
         return shift_type'((int'(b) + k) % SHIFT_COUNT);
      endfunction

      function shift_set_type classify_shifts();
         int            p;
         int            r0;
         int            r1;
         int            r2;
         int            t;
         shift_type     base;
         shift_set_type res;
         if (phase_mode == PHASE_SINGLE) begin
            for (p = 0; p < PORT_COUNT; p++) begin
               if (port_enable[p]) begin
                  port_shift[p] = one_phase_shift(bin_sextant(port_deg[p]));
               end
            end
         end else begin
            // Rank by current; swap only on strictly smaller so ties keep index order
            r0 = 0;
            r1 = 1;
            r2 = 2;
            if (port_cur[r0] < port_cur[r1]) begin
               t = r0; r0 = r1; r1 = t;
            end
            if (port_cur[r1] < port_cur[r2]) begin
               t = r1; r1 = r2; r2 = t;
            end
            if (port_cur[r0] < port_cur[r1]) begin
               t = r0; r0 = r1; r1 = t;
            end
            base = bin_sextant(port_deg[r0]);
            port_shift[r0] = base;
            if (leads(port_deg[r0], port_deg[r1])) begin
               port_shift[r1] = rotate(base, 4);
               port_shift[r2] = rotate(base, 2);
            end else begin
               port_shift[r1] = rotate(base, 2);
               port_shift[r2] = rotate(base, 4);
            end
         end
         for (p = 0; p < PORT_COUNT; p++) begin
            res[p] = port_shift[p];
         end
         return res;
      endfunction

      function void note_request(logic mode, port_type idx, logic signed [31:0] ang,
                                 logic signed [31:0] cur);
         if (mode == MODE_PUSH) begin
            if (idx < PORT_COUNT) begin
               port_deg[idx] = round_degrees(ang);
               port_cur[idx] = cur;
            end
         end else begin
            expected_shifts.push_back(classify_shifts());
         end
      endfunction

      function int pending();
         return expected_shifts.size();
      endfunction

      task report(string msg);
         $display("ERROR at %0t: %s", $realtime, msg);
         fail_count++;
      endtask

      task check_shifts(shift_set_type got);
         shift_set_type want;
         int            p;
         if (expected_shifts.size() == 0) begin
            report($sformatf("result %0d/%0d/%0d with nothing outstanding",
                             got[0], got[1], got[2]));
            return;
         end
         want = expected_shifts.pop_front();
         for (p = 0; p < PORT_COUNT; p++) begin
            if (got[p] !== want[p]) begin
               report($sformatf("shift_port%0d got %0d expected %0d", p, got[p], want[p]));
            end
         end
      endtask
   endclass

   localparam int       ONE_DEGREE     = 1 << FRAC_BITS;
   localparam int       HALF_DEGREE    = ONE_DEGREE / 2;
   localparam int       MAX_GAP        = 7;
   localparam int       SETTLE_CYCLES  = 8;
   localparam int       WATCHDOG_LIMIT = 1000;
   localparam int       PHASES         = 12;
   localparam int       PHASE_ITEMS    = 125;
   localparam port_type NO_PORT        = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_mode;
   logic [1:0]            req_port_index;
   logic signed [31:0]    req_angle_q;
   logic signed [31:0]    req_current_rms;
   logic                  rsp_valid;
   logic [2:0]            rsp_shift_port0;
   logic [2:0]            rsp_shift_port1;
   logic [2:0]            rsp_shift_port2;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   shift_tracker tracker;
   int           gap_max;
   int           idle_cycles;

   phase_shift_classifier u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_port_index  (req_port_index),
      .req_angle_q     (req_angle_q),
      .req_current_rms (req_current_rms),
      .rsp_valid       (rsp_valid),
      .rsp_shift_port0 (rsp_shift_port0),
      .rsp_shift_port1 (rsp_shift_port1),
      .rsp_shift_port2 (rsp_shift_port2),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Check every result strobe against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         tracker.check_shifts({rsp_shift_port2, rsp_shift_port1, rsp_shift_port0});
      end
   end

   // Stop the run when no transfer of any kind happens for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int angle_of(int deg);
      return deg * ONE_DEGREE;
   endfunction

   // Mix of full-range words, angles of -200 to 200 degrees with a fractional offset, sextant edges and clamp edges
   function automatic logic signed [31:0] rand_angle();
      int d;
      int f;
      case ($urandom_range(0, 3))
         0: begin
            return $urandom;
         end
         1: begin
            d = $urandom_range(0, 400);
            f = $urandom_range(0, 2 * ONE_DEGREE - 2);
            return angle_of(d - 200) + f - (ONE_DEGREE - 1);
         end
         2: begin
            d = $urandom_range(0, 12);
            d = d * 30 - 180;
            f = $urandom_range(0, 2);
            d = d + f - 1;
            f = $urandom_range(0, 1) ? HALF_DEGREE : HALF_DEGREE - 1;
            if ($urandom_range(0, 2) == 0) begin
               f = 0;
            end
            if ($urandom_range(0, 1)) begin
               f = -f;
            end
            return angle_of(d) + f;
         end
         default: begin
            d = $urandom_range(178, 183);
            f = $urandom_range(0, ONE_DEGREE - 1);
            return $urandom_range(0, 1) ? angle_of(d) + f : -(angle_of(d) + f);
         end
      endcase
   endfunction

   // Full-range words, small values that tie often, and the extremes
   function automatic logic signed [31:0] rand_current();
      case ($urandom_range(0, 2))
         0: begin
            return $urandom;
         end
         1: begin
            return $urandom_range(0, 3);
         end
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7fffffff;
               1: return 32'sh80000000;
               2: return 32'sh00000000;
               default: return -32'sd1;
            endcase
         end
      endcase
   endfunction

   // Hold a request until the block takes it, after a random gap
   task automatic send_request(logic mode, port_type idx, logic signed [31:0] ang,
                               logic signed [31:0] cur);
      int gap;
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start           <= 1'b1;
      req_mode        <= mode;
      req_port_index  <= idx;
      req_angle_q     <= ang;
      req_current_rms <= cur;
      do @(posedge clock); while (busy);
      tracker.note_request(mode, idx, ang, cur);
   endtask

   task automatic push_port(port_type idx, logic signed [31:0] ang, logic signed [31:0] cur);
      send_request(MODE_PUSH, idx, ang, cur);
   endtask

   task automatic calculate();
      send_request(MODE_CALC, port_type'($urandom_range(0, 3)), $urandom, $urandom);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drop start, drain outstanding results and let a trailing push finish
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int         ph;
      int         sent;
      int         n;
      int         first;
      int         k;
      port_type   idx;
      logic [2:0] mode_data;
      logic [2:0] en_data;

      tracker         = new();
      clock           = 1'b0;
      reset           = 1'b1;
      start           = 1'b0;
      req_mode        = MODE_PUSH;
      req_port_index  = '0;
      req_angle_q     = '0;
      req_current_rms = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_PHASE_MODE;
      csr_wdata       = '0;
      gap_max         = MAX_GAP;
      idle_cycles     = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset state, field extremes, rounding and clamping, ignored port index
      calculate();
      push_port(2'd0, 32'sh7fffffff, 32'sh7fffffff);
      push_port(2'd1, 32'sh80000000, 32'sh80000000);
      push_port(2'd2, HALF_DEGREE, 0);
      push_port(NO_PORT, -1, -1);
      calculate();
      push_port(2'd0, -HALF_DEGREE, 5);
      push_port(2'd1, HALF_DEGREE - 1, 6);
      push_port(2'd2, -(angle_of(180) + HALF_DEGREE), 7);
      calculate();

      // Disabled ports keep their shift
      settle();
      write_csr(CSR_PORT_ENABLE, 3'b010);
      push_port(2'd1, angle_of(90), 0);
      push_port(2'd0, angle_of(150), 0);
      calculate();

      // Three-phase: tied currents, a new leader, leading and trailing second port
      settle();
      write_csr(CSR_PHASE_MODE, {2'b00, PHASE_THREE});
      write_csr(CSR_SPARE_HI, 3'b111);
      push_port(2'd0, angle_of(10), 100);
      push_port(2'd1, angle_of(100), 100);
      push_port(2'd2, angle_of(-100), 100);
      calculate();
      push_port(2'd2, angle_of(-100), 500);
      calculate();
      push_port(2'd0, angle_of(179), 32'sh7fffffff);
      push_port(2'd1, angle_of(-1), 0);
      calculate();
      push_port(2'd1, angle_of(0), 0);
      calculate();

      // Random phases, each under its own register setting
      for (ph = 0; ph < PHASES; ph++) begin
         settle();
         if (ph < 4) begin
            mode_data = {2'b00, (ph >= 2) ? PHASE_THREE : PHASE_SINGLE};
            en_data   = ph[0] ? 3'b000 : 3'b111;
         end else begin
            mode_data = 3'($urandom_range(0, 7));
            en_data   = 3'($urandom_range(0, 7));
         end
         write_csr(CSR_PHASE_MODE, mode_data);
         write_csr(CSR_PORT_ENABLE, en_data);
         if ($urandom_range(0, 3) == 0) begin
            write_csr($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO,
                      3'($urandom_range(0, 7)));
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            if ($urandom_range(0, 9) < 6) begin
               // Refresh some ports, then calculate
               n     = $urandom_range(1, 3);
               first = $urandom_range(0, 2);
               for (k = 0; k < n; k++) begin
                  push_port(port_type'((first + k) % PORT_COUNT), rand_angle(), rand_current());
               end
               calculate();
               sent += n + 1;
            end else if ($urandom_range(0, 3) == 0) begin
               calculate();
               sent++;
            end else begin
               idx = port_type'($urandom_range(0, 3));
               push_port(idx, rand_angle(), rand_current());
               if (idx != NO_PORT) begin
                  sent++;
               end
            end
         end
      end

      settle();
      if (tracker.fail_count == 0 && tracker.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ phase_shift_classifier.f @@
sv/psc_pkg.sv
sv/psc_conv.sv
sv/psc_cmp.sv
sv/phase_shift_classifier.sv
dv/tb.sv
